### sv/sscan_pkg.sv
package sscan_pkg;

  // saturation limit and blank port word
  localparam logic [13:0] NumMax = 14'd9999;
  localparam logic [11:0] Blank  = 12'hFFF;

  // position of a digit, thousands first
  localparam logic [1:0] PosThousands = 2'd0;
  localparam logic [1:0] PosHundreds  = 2'd1;
  localparam logic [1:0] PosTens      = 2'd2;
  localparam logic [1:0] PosOnes      = 2'd3;

  // active-low digit selects
  localparam logic [3:0] SelThousands = 4'hE;
  localparam logic [3:0] SelHundreds  = 4'hD;
  localparam logic [3:0] SelTens      = 4'hB;
  localparam logic [3:0] SelOnes      = 4'h7;

  // one classified number: start position and four bcd digits
  typedef struct packed {
    logic [1:0]      first;
    logic [3:0][3:0] digit;
  } entry_t;

  // active-low gfedcba segments
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] digit_sel(input logic [1:0] pos);
    logic [3:0] s;
    case (pos)
      PosThousands: s = SelThousands;
      PosHundreds:  s = SelHundreds;
      PosTens:      s = SelTens;
      PosOnes:      s = SelOnes;
      default:      s = SelOnes;
    endcase
    return s;
  endfunction

endpackage

### sv/sscan_front.sv
module sscan_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [13:0]       number_i,
  output logic              push_o,
  output sscan_pkg::entry_t push_data_o,
  input  logic              q_full_i
);

  // stage 1: saturate, thousands digit, start position
  logic       s1_valid_q;
  logic [3:0] s1_d3_q;
  logic [9:0] s1_rem_q;
  logic [1:0] s1_first_q;
  // stage 2: hundreds digit
  logic       s2_valid_q;
  logic [3:0] s2_d3_q, s2_d2_q;
  logic [6:0] s2_rem_q;
  logic [1:0] s2_first_q;
  // stage 3: tens and ones, ready for the queue
  logic              s3_valid_q;
  sscan_pkg::entry_t s3_entry_q;

  logic        adv;
  logic [13:0] sat;
  logic [3:0]  d3_d, d2_d, d1_d;
  logic [13:0] sub3;
  logic [9:0]  sub2;
  logic [6:0]  sub1;
  logic [1:0]  first_d;
  logic [9:0]  rem3_d;
  logic [6:0]  rem2_d;
  logic [3:0]  rem1_d;

  assign adv         = !(s3_valid_q && q_full_i);
  assign in_stall_o  = !adv;
  assign push_o      = s3_valid_q && !q_full_i;
  assign push_data_o = s3_entry_q;

  always_comb begin
    sat = (number_i > sscan_pkg::NumMax) ? sscan_pkg::NumMax : number_i;
    d3_d = 4'd0;
    sub3 = 14'd0;
    for (int k = 1; k < 10; k++) begin
      if (sat >= 14'(k * 1000)) begin
        d3_d = 4'(k);
        sub3 = 14'(k * 1000);
      end
    end
    rem3_d = 10'(sat - sub3);
    if (sat >= 14'd1000) begin
      first_d = sscan_pkg::PosThousands;
    end else if (sat >= 14'd100) begin
      first_d = sscan_pkg::PosHundreds;
    end else if (sat >= 14'd10) begin
      first_d = sscan_pkg::PosTens;
    end else begin
      first_d = sscan_pkg::PosOnes;
    end

    d2_d = 4'd0;
    sub2 = 10'd0;
    for (int k = 1; k < 10; k++) begin
      if (s1_rem_q >= 10'(k * 100)) begin
        d2_d = 4'(k);
        sub2 = 10'(k * 100);
      end
    end
    rem2_d = 7'(s1_rem_q - sub2);

    d1_d = 4'd0;
    sub1 = 7'd0;
    for (int k = 1; k < 10; k++) begin
      if (s2_rem_q >= 7'(k * 10)) begin
        d1_d = 4'(k);
        sub1 = 7'(k * 10);
      end
    end
    rem1_d = 4'(s2_rem_q - sub1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_d3_q    <= d3_d;
      s1_rem_q   <= rem3_d;
      s1_first_q <= first_d;
      s2_d3_q    <= s1_d3_q;
      s2_d2_q    <= d2_d;
      s2_rem_q   <= rem2_d;
      s2_first_q <= s1_first_q;
      s3_entry_q.first    <= s2_first_q;
      s3_entry_q.digit[0] <= s2_d3_q;
      s3_entry_q.digit[1] <= s2_d2_q;
      s3_entry_q.digit[2] <= d1_d;
      s3_entry_q.digit[3] <= rem1_d;
    end
  end

endmodule

### sv/sscan_queue.sv
module sscan_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sscan_pkg::entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output sscan_pkg::entry_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sscan_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/sscan_back.sv
module sscan_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  sscan_pkg::entry_t q_head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [11:0]       port_word_o,
  output logic              last_o
);

  logic            busy_q, busy_d;
  logic [1:0]      pos_q, pos_d;
  logic            phase_q, phase_d;
  logic [3:0][3:0] digit_q, digit_d;
  logic            out_valid_q;
  logic [11:0]     word_q, word_d;
  logic            last_q, last_d;
  logic            out_ready, emit, finishing;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && out_ready;
  assign finishing = emit && phase_q && (pos_q == sscan_pkg::PosOnes);
  assign pop_o     = q_valid_i && (!busy_q || finishing);

  always_comb begin
    busy_d  = busy_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    digit_d = digit_q;
    word_d  = phase_q ? sscan_pkg::Blank
                      : {sscan_pkg::digit_sel(pos_q), sscan_pkg::seg_code(digit_q[pos_q])};
    last_d  = phase_q && (pos_q == sscan_pkg::PosOnes);
    if (pop_o) begin
      busy_d  = 1'b1;
      pos_d   = q_head_i.first;
      phase_d = 1'b0;
      digit_d = q_head_i.digit;
    end else if (finishing) begin
      busy_d = 1'b0;
    end else if (emit) begin
      phase_d = !phase_q;
      if (phase_q) begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      if (out_ready) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    if (emit) begin
      word_q <= word_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign port_word_o = word_q;
  assign last_o      = last_q;

endmodule

### sv/seven_segment_number_scan_top.sv
// path: front pipeline, queue, back-end sequencer, then registered port word output
// throughput: one port word per cycle unless out_stall_i holds, two per shown digit,
//   set by the back end; the front takes a number per cycle while the queue has room
// reset: rst_ni is asynchronous and active low; it empties the pipeline, the queue and
//   the output register, and no words are pending afterwards
module seven_segment_number_scan_top #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // number channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [13:0] number_i,
  // port word channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] port_word_o,
  output logic        last_o
);

  // front to queue
  logic              push;
  logic              q_full;
  sscan_pkg::entry_t push_data;
  // queue to back
  logic              pop;
  logic              q_valid;
  sscan_pkg::entry_t q_head;

  // front: saturates the number, splits it into bcd digits over three stages
  // and finds the most significant shown digit
  sscan_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  // short queue of classified items so each side can stall on its own
  sscan_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // back: walks the shown digits, a digit word then a blank word for each,
  // and loads the next item while the last blank word goes out
  sscan_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .port_word_o (port_word_o),
    .last_o      (last_o)
  );

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // receiver hold-off length for the back-pressure test, in clock cycles
  localparam int HoldCycles = 80;
  // cycles to watch after the last word for anything stray
  localparam int TailCycles = 20;
  localparam int ReportLimit = 10;

  // active-low gfedcba patterns, one per decimal digit
  localparam logic [7:0] SegLit [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  // digit selects, thousands place first
  localparam logic [3:0] PlaceSel [4] = '{
    sscan_pkg::SelThousands, sscan_pkg::SelHundreds, sscan_pkg::SelTens, sscan_pkg::SelOnes
  };

  typedef struct packed {
    logic [11:0] word;
    logic        last;
  } scan_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [13:0] number_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [11:0] port_word_o;
  logic        last_o;

  // words still owed by the block, oldest first
  scan_word_t pending_words[$];

  int errors = 0;
  int words_seen = 0;
  int numbers_sent = 0;
  int saturated = 0;
  int shown_len[5] = '{0, 0, 0, 0, 0};

  // sender burst state
  int  burst_left = 0;
  bit  no_gaps = 1'b0;

  // handshake with the receiver for the long hold-off
  bit  hold_req = 1'b0;
  bit  hold_active = 1'b0;

  seven_segment_number_scan_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .port_word_o (port_word_o),
    .last_o      (last_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= ReportLimit) $display("mismatch: %s", msg);
  endfunction

  // work out the words one number scans to and queue them
  function automatic void predict_scan(input logic [13:0] value);
    int v;
    int first;
    int place_digit[4];
    scan_word_t w;
    v = int'(value);
    if (v > int'(sscan_pkg::NumMax)) begin
      v = int'(sscan_pkg::NumMax);
      saturated++;
    end
    place_digit[0] = v / 1000;
    place_digit[1] = (v / 100) % 10;
    place_digit[2] = (v / 10) % 10;
    place_digit[3] = v % 10;
    // leading zeros blanked, zero itself still shows one digit
    if (v >= 1000) first = 0;
    else if (v >= 100) first = 1;
    else if (v >= 10) first = 2;
    else first = 3;
    shown_len[4 - first]++;
    for (int p = first; p < 4; p++) begin
      w.word = {PlaceSel[p], SegLit[place_digit[p]]};
      w.last = 1'b0;
      pending_words.push_back(w);
      w.word = sscan_pkg::Blank;
      w.last = (p == 3);
      pending_words.push_back(w);
    end
  endfunction

  // offer one number; entered and left at a falling edge
  task automatic send_number(input logic [13:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    number_i   <= value;
    // taken at the first rising edge with stall low
    do @(posedge clk_i); while (in_stall_o);
    predict_scan(value);
    numbers_sent++;
    @(negedge clk_i);
  endtask

  // sender goes quiet until every owed word has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [13:0] pick_number();
    int kind;
    logic [13:0] n;
    kind = $urandom_range(0, 9);
    case (kind)
      0:       n = 14'($urandom_range(0, 9));
      1:       n = 14'($urandom_range(10, 99));
      2:       n = 14'($urandom_range(100, 999));
      3, 4, 5: n = 14'($urandom_range(1000, 9999));
      6, 7:    n = 14'($urandom_range(10000, 16383));
      default: n = 14'($urandom_range(0, 16383));
    endcase
    return n;
  endfunction

  // width boundaries, range edges, a spread of digits in each place, saturation
  task automatic test_directed();
    logic [13:0] list[$];
    list = '{14'd0, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999, 14'd1000, 14'd9999,
             14'd10000, 14'd16383, 14'd1234, 14'd5678, 14'd9012, 14'd3456, 14'd7890,
             14'd1, 14'd4050, 14'd8191, 14'h2AAA, 14'h1555, 14'd6002};
    foreach (list[i]) send_number(list[i]);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_number(pick_number());
  endtask

  // receiver holds off long enough for the queue to fill and stall the input
  task automatic test_back_pressure(input int count);
    wait_drained();
    hold_req = 1'b1;
    wait (hold_active);
    @(negedge clk_i);
    no_gaps = 1'b1;
    repeat (count) send_number(pick_number());
    no_gaps = 1'b0;
  endtask

  // sender pauses until the block is empty, then resumes
  task automatic test_drain_pause(input int count);
    repeat (count / 2) send_number(pick_number());
    wait_drained();
    repeat (count - count / 2) send_number(pick_number());
  endtask

  // receiver: random stall modes plus a counted hold-off on request
  initial begin : receiver
    int left;
    int mode;
    int cyc;
    left = 0;
    mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_active = 1'b0;
      end
      if (left == 0) begin
        left = $urandom_range(16, 64);
        mode = $urandom_range(0, 3);
      end
      left--;
      cyc++;
      case (mode)
        0:       out_stall_i <= 1'b0;                          // free flowing
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);   // light
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);   // heavy
        default: out_stall_i <= ((cyc % 5) < 2);               // fixed beat
      endcase
    end
  end

  // compare each accepted word against the oldest owed one
  always @(posedge clk_i) begin : check_words
    scan_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        note_error($sformatf("stray word %h last %b", port_word_o, last_o));
      end else begin
        want = pending_words.pop_front();
        words_seen++;
        if (port_word_o !== want.word)
          note_error($sformatf("port_word expected %h got %h", want.word, port_word_o));
        if (last_o !== want.last)
          note_error($sformatf("last expected %b got %b (word %h)",
                               want.last, last_o, want.word));
      end
    end
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d words still owed", pending_words.size());
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : main
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(170);
    test_back_pressure(40);
    test_drain_pause(40);
    test_random(160);

    // let the last words out, then watch for stragglers
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (pending_words.size() != 0)
      note_error($sformatf("%0d words never came out", pending_words.size()));

    $display("covered %0d numbers (%0d saturated), %0d port words checked",
             numbers_sent, saturated, words_seen);
    $display("shown widths 1/2/3/4 digits: %0d/%0d/%0d/%0d, %0d mismatches",
             shown_len[1], shown_len[2], shown_len[3], shown_len[4], errors);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
